// ===== src/hbsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbsd_pkg
// Shared constants and types for the bit-serial Huffman decoder.
// ----------------------------------------------------------------------------
package hbsd_pkg;

  localparam int SYMBOLS      = 256;
  localparam int MAX_CODE_LEN = 64;
  localparam int CODE_W       = 64;
  localparam int LEN_W        = 7;
  localparam int SYM_W        = 8;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_END_MID  = 2'd2
  } status_t;

  // Search token passed from cell to cell.
  typedef struct packed {
    logic             probe;
    logic             found;
    logic [SYM_W-1:0] sym;
  } link_t;

endpackage
`default_nettype wire

// ===== src/huffman_bit_serial_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_bit_serial_decoder_unit
// Bit-serial Huffman decoder built on a chain of dictionary cells.
// ----------------------------------------------------------------------------
// Timing: a load transfer is taken while idle and leaves the block idle. A
//   decode transfer enters SEARCH and launches a search token that walks the
//   cell chain, one cell a cycle; FINISH then hands any result to the output
//   register. An over-long code goes straight to FINISH.
// Throughput: one load per cycle while idle; no transfer is taken until a
//   decode bit has left FINISH; a result held by out_stall holds FINISH.
// Reset: rst (synchronous) clears every dictionary length, the accumulator
//   and all control state; usable the cycle after reset drops.
module huffman_bit_serial_decoder_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        action,
  input  wire logic [7:0]                  entry_index,
  input  wire logic [6:0]                  entry_length,
  input  wire logic [63:0]                 entry_code,
  input  wire logic                        bit_in,
  input  wire logic                        stream_end,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       symbol,
  output logic [1:0]                       status
);

  typedef enum logic [1:0] {IDLE, SEARCH, FINISH} state_t;

  state_t                       state;
  logic [hbsd_pkg::CODE_W-1:0]  acc_code;
  logic [hbsd_pkg::LEN_W-1:0]   acc_length;
  logic                         last;       // stream_end of bit in flight
  logic                         launch;     // token injection pulse
  logic                         res_has;    // result pending in FINISH
  logic [hbsd_pkg::SYM_W-1:0]   res_sym;
  hbsd_pkg::status_t            res_status;

  logic                         in_xfer;
  logic                         load_en;
  logic                         res_load;   // pending result moves to output
  logic [hbsd_pkg::LEN_W-1:0]   new_len;
  hbsd_pkg::link_t              links [0:hbsd_pkg::SYMBOLS];

  assign in_stall = (state != IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign load_en  = in_xfer && (action == hbsd_pkg::ACT_LOAD);
  assign new_len  = acc_length + hbsd_pkg::LEN_W'(1);
  assign res_load = (state == FINISH) && res_has && (!out_valid || !out_stall);

  assign links[0] = '{probe: launch, found: 1'b0, sym: '0};

  // The cell chain: each cell holds one entry and compares against the
  // accumulator, which stays still while the token travels.
  for (genvar i = 0; i < hbsd_pkg::SYMBOLS; i++) begin : g_cell
    hbsd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_id   (hbsd_pkg::SYM_W'(i)),
      .wr_en     (load_en),
      .wr_index  (entry_index),
      .wr_length (entry_length),
      .wr_code   (entry_code),
      .q_length  (acc_length),
      .q_code    (acc_code),
      .link_in   (links[i]),
      .link_out  (links[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      acc_code   <= '0;
      acc_length <= '0;
      launch     <= 1'b0;
      res_has    <= 1'b0;
      out_valid  <= 1'b0;
      last       <= 1'b0;
      res_sym    <= '0;
      res_status <= hbsd_pkg::ST_OK;
      symbol     <= '0;
      status     <= '0;
    end else begin
      launch <= 1'b0;
      // output register: a new result may replace one leaving this cycle
      if (res_load) begin
        out_valid <= 1'b1;
        symbol    <= res_sym;
        status    <= res_status;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_xfer && (action == hbsd_pkg::ACT_DECODE)) begin
            if (32'(new_len) > hbsd_pkg::MAX_CODE_LEN) begin
              // code too long: report and drop the partial code
              acc_code   <= '0;
              acc_length <= '0;
              res_has    <= 1'b1;
              res_sym    <= '0;
              res_status <= hbsd_pkg::ST_TOO_LONG;
              state      <= FINISH;
            end else begin
              acc_code   <= {acc_code[hbsd_pkg::CODE_W-2:0], bit_in};
              acc_length <= new_len;
              last       <= stream_end;
              launch     <= 1'b1;
              state      <= SEARCH;
            end
          end
        end
        SEARCH: begin
          if (links[hbsd_pkg::SYMBOLS].probe) begin
            if (links[hbsd_pkg::SYMBOLS].found) begin
              acc_code   <= '0;
              acc_length <= '0;
              res_has    <= 1'b1;
              res_sym    <= links[hbsd_pkg::SYMBOLS].sym;
              res_status <= hbsd_pkg::ST_OK;
            end else if (last) begin
              acc_code   <= '0;
              acc_length <= '0;
              res_has    <= 1'b1;
              res_sym    <= '0;
              res_status <= hbsd_pkg::ST_END_MID;
            end else begin
              res_has <= 1'b0;
            end
            state <= FINISH;
          end
        end
        FINISH: begin
          // hand the result to the output register once it is free
          if (!res_has) begin
            state <= IDLE;
          end else if (res_load) begin
            res_has <= 1'b0;
            state   <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/hbsd_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbsd_cell
// One dictionary entry; compares it with the accumulated code as the
// search token passes by and forwards the token one cell per cycle.
// ----------------------------------------------------------------------------
module hbsd_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [hbsd_pkg::SYM_W-1:0]  cell_id,
  input  wire logic                        wr_en,
  input  wire logic [hbsd_pkg::SYM_W-1:0]  wr_index,
  input  wire logic [hbsd_pkg::LEN_W-1:0]  wr_length,
  input  wire logic [hbsd_pkg::CODE_W-1:0] wr_code,
  input  wire logic [hbsd_pkg::LEN_W-1:0]  q_length,
  input  wire logic [hbsd_pkg::CODE_W-1:0] q_code,
  input  wire hbsd_pkg::link_t             link_in,
  output hbsd_pkg::link_t                  link_out
);

  logic [hbsd_pkg::LEN_W-1:0]  length;
  logic [hbsd_pkg::CODE_W-1:0] code;
  logic                        hit;

  assign hit = (length == q_length) && (code == q_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      length         <= '0;
      link_out.probe <= 1'b0;
      link_out.found <= 1'b0;
    end else begin
      if (wr_en && (wr_index == cell_id)) begin
        length <= wr_length;
      end
      link_out.probe <= link_in.probe;
      link_out.found <= link_in.found | (link_in.probe & hit);
    end
    if (wr_en && (wr_index == cell_id)) begin
      code <= wr_code;
    end
    // lowest index wins: keep an earlier hit
    link_out.sym <= link_in.found ? link_in.sym : cell_id;
  end

endmodule
`default_nettype wire

// ===== src/hbsd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbsd_checker
// Port-level checks for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hbsd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       action,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] symbol,
  input wire logic [1:0] status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(status))
    else $error("result dropped while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == hbsd_pkg::ST_OK || status == hbsd_pkg::ST_TOO_LONG ||
                   status == hbsd_pkg::ST_END_MID))
    else $error("bad status code");

  a_err_sym: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != hbsd_pkg::ST_OK |-> symbol == 8'd0)
    else $error("error result carries a symbol");

  a_decode_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action |=> in_stall)
    else $error("decode transfer did not occupy the block");

endmodule

bind huffman_bit_serial_decoder_unit hbsd_checker u_hbsd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .action    (action),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .symbol    (symbol),
  .status    (status)
);
`default_nettype wire

// ===== dv/huffman_bit_serial_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bit_serial_decoder_unit_tb
// Self-checking bench for the bit-serial Huffman decoder. A directed table
// covers empty-dictionary, priority, stream-end and stray-bit cases; random
// prefix codebooks are then loaded and streamed bit by bit, with noise loads,
// broken streams, a full 64-bit code and an over-long code. Every result is
// checked against an in-bench decoder model.
// ----------------------------------------------------------------------------
module huffman_bit_serial_decoder_unit_tb;

  localparam int  ITEMS_TARGET = 1400;
  localparam int  CYCLE_LIMIT  = 1500000;
  localparam int  DRAIN_CYCLES = hbsd_pkg::SYMBOLS + 40;
  localparam int  HOLD_CYCLES  = 2000;

  typedef struct packed {
    logic [hbsd_pkg::SYM_W-1:0] sym;
    hbsd_pkg::status_t          st;
  } decoded_t;

  // One directed row; chk marks rows whose result is typed in by hand.
  typedef struct {
    logic                       act;
    logic [7:0]                 idx;
    logic [6:0]                 len;
    logic [63:0]                code;
    logic                       b;
    logic                       e;
    bit                         chk;
    logic [hbsd_pkg::SYM_W-1:0] sym;
    hbsd_pkg::status_t          st;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = hbsd_pkg::ACT_LOAD;
  logic [7:0]  entry_index = '0;
  logic [6:0]  entry_length = '0;
  logic [63:0] entry_code = '0;
  logic        bit_in = 1'b0;
  logic        stream_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  symbol;
  logic [1:0]  status;

  // Decoder model state
  logic [hbsd_pkg::CODE_W-1:0] dict_code_m [hbsd_pkg::SYMBOLS];
  logic [hbsd_pkg::LEN_W-1:0]  dict_len_m  [hbsd_pkg::SYMBOLS];
  logic [hbsd_pkg::CODE_W-1:0] acc_code_m;
  logic [hbsd_pkg::LEN_W-1:0]  acc_len_m;

  decoded_t pending_q[$];
  int       errors = 0;
  int       n_sent = 0;
  int       cycles = 0;
  bit       quiet = 1'b0;     // no idling on either side
  bit       hold_req = 1'b0;  // receiver holds off for a long stretch

  dir_row_t dir_tbl[19];

  always #5 clk = ~clk;

  huffman_bit_serial_decoder_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .entry_index(entry_index), .entry_length(entry_length),
    .entry_code(entry_code), .bit_in(bit_in), .stream_end(stream_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .symbol(symbol), .status(status)
  );

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH @%0t %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Decoder model: one input transfer, zero or one decoded result.
  task automatic decode_step(input logic act, input logic [7:0] idx, input logic [6:0] len,
                             input logic [63:0] code, input logic b, input logic e,
                             output bit has, output decoded_t res);
    logic [hbsd_pkg::LEN_W-1:0] nlen;
    has = 1'b0;
    res = '{sym: '0, st: hbsd_pkg::ST_OK};
    if (act == hbsd_pkg::ACT_LOAD) begin
      dict_code_m[idx] = code;
      dict_len_m[idx]  = len;
      return;
    end
    nlen = acc_len_m + hbsd_pkg::LEN_W'(1);
    if (int'(nlen) > hbsd_pkg::MAX_CODE_LEN) begin
      acc_code_m = '0;
      acc_len_m  = '0;
      has = 1'b1;
      res.st = hbsd_pkg::ST_TOO_LONG;
      return;
    end
    acc_code_m = {acc_code_m[hbsd_pkg::CODE_W-2:0], b};
    acc_len_m  = nlen;
    for (int i = 0; i < hbsd_pkg::SYMBOLS; i++) begin
      if (!has && dict_len_m[i] == nlen && dict_code_m[i] == acc_code_m) begin
        has = 1'b1;
        res.sym = i[hbsd_pkg::SYM_W-1:0];
      end
    end
    if (!has && e) begin
      has = 1'b1;
      res.st = hbsd_pkg::ST_END_MID;
    end
    if (has) begin
      acc_code_m = '0;
      acc_len_m  = '0;
    end
  endtask

  // Offer one transfer; idle gap first at random. Returns the model result.
  task automatic offer(input logic act, input logic [7:0] idx, input logic [6:0] len,
                       input logic [63:0] code, input logic b, input logic e,
                       output bit has, output decoded_t res);
    if (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    entry_index  <= idx;
    entry_length <= len;
    entry_code   <= code;
    bit_in       <= b;
    stream_end   <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_step(act, idx, len, code, b, e, has, res);
    if (has) pending_q.push_back(res);
    n_sent++;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Load with unrelated decode fields randomized.
  task automatic load_entry(input logic [7:0] idx, input logic [6:0] len, input logic [63:0] code);
    bit has;
    decoded_t res;
    offer(hbsd_pkg::ACT_LOAD, idx, len, code, 1'($urandom_range(1)), 1'($urandom_range(1)),
          has, res);
  endtask

  // Decode bit with unrelated load fields randomized.
  task automatic decode_bit(input logic b, input logic e);
    bit has;
    decoded_t res;
    offer(hbsd_pkg::ACT_DECODE, 8'($urandom_range(255)), 7'($urandom_range(127)), rnd64(),
          b, e, has, res);
  endtask

  // Random complete prefix codebook of k symbols, then a stream of its codes.
  task automatic codebook_segment();
    int k, nsym, sel;
    logic [63:0] mask;
    logic [7:0]  ids [8];
    logic [63:0] codes [8];
    int          lens [8];
    bit          used [hbsd_pkg::SYMBOLS];
    bit          brk;
    k = $urandom_range(8, 2);
    mask = rnd64();
    foreach (used[i]) used[i] = 1'b0;
    for (int j = 0; j < k; j++) begin
      do ids[j] = 8'($urandom_range(255)); while (used[ids[j]]);
      used[ids[j]] = 1'b1;
      // j ones then a zero; the last symbol is all ones. XOR by position keeps it prefix-free.
      lens[j] = (j < k - 1) ? j + 1 : k - 1;
      codes[j] = '0;
      for (int p = 0; p < lens[j]; p++)
        codes[j] = {codes[j][62:0], ((p < j) ? 1'b1 : 1'b0) ^ mask[p]};
      load_entry(ids[j], lens[j][6:0], codes[j]);
    end
    repeat ($urandom_range(3))
      load_entry(8'($urandom_range(255)), 7'($urandom_range(127)), rnd64());
    nsym = $urandom_range(30, 8);
    for (int s = 0; s < nsym; s++) begin
      sel = $urandom_range(k - 1);
      for (int p = lens[sel] - 1; p >= 0; p--) begin
        brk = ($urandom_range(99) < 2);  // cut the stream mid-code now and then
        if ($urandom_range(99) < 3)
          decode_bit(1'($urandom_range(1)), 1'b0);  // stray bit
        decode_bit(codes[sel][p], brk || (s == nsym - 1 && p == 0));
      end
    end
  endtask

  // Result check
  always @(posedge clk) begin
    decoded_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report("unexpected result", 64'({symbol, status}), '0);
      end else begin
        want = pending_q.pop_front();
        if (symbol !== want.sym) report("symbol", 64'(symbol), 64'(want.sym));
        if (status !== want.st)  report("status", 64'(status), 64'(want.st));
      end
    end
  end

  // Receiver stall; a long hold-off on request, counted here.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 23);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    bit       has;
    decoded_t res;
    logic [63:0] c64;

    dir_tbl = '{
      // empty dictionary: a stream end bit finds nothing
      '{hbsd_pkg::ACT_DECODE, 8'd0,   7'd0,   64'd0, 1'b1, 1'b1, 1, 8'd0,   hbsd_pkg::ST_END_MID},
      '{hbsd_pkg::ACT_LOAD,   8'd0,   7'd0,   64'd0, 1'b0, 1'b0, 0, 8'd0,   hbsd_pkg::ST_OK},
      // length zero entry never matches
      '{hbsd_pkg::ACT_DECODE, 8'd0,   7'd0,   64'd0, 1'b0, 1'b1, 1, 8'd0,   hbsd_pkg::ST_END_MID},
      '{hbsd_pkg::ACT_LOAD,   8'd255, 7'd1,   64'd1, 1'b0, 1'b0, 0, 8'd0,   hbsd_pkg::ST_OK},
      '{hbsd_pkg::ACT_LOAD,   8'd3,   7'd1,   64'd1, 1'b0, 1'b0, 0, 8'd0,   hbsd_pkg::ST_OK},
      // lowest index wins
      '{hbsd_pkg::ACT_DECODE, 8'd0,   7'd0,   64'd0, 1'b1, 1'b0, 1, 8'd3,   hbsd_pkg::ST_OK},
      '{hbsd_pkg::ACT_LOAD,   8'd7,   7'd2,   64'd0, 1'b0, 1'b0, 0, 8'd0,   hbsd_pkg::ST_OK},
      '{hbsd_pkg::ACT_DECODE, 8'd0,   7'd0,   64'd0, 1'b0, 1'b0, 0, 8'd0,   hbsd_pkg::ST_OK},
      // match on the last bit
      '{hbsd_pkg::ACT_DECODE, 8'd0,   7'd0,   64'd0, 1'b0, 1'b1, 1, 8'd7,   hbsd_pkg::ST_OK},
      // stray bits above the length
      '{hbsd_pkg::ACT_LOAD,   8'd9,   7'd2,   64'd7, 1'b0, 1'b0, 0, 8'd0,   hbsd_pkg::ST_OK},
      '{hbsd_pkg::ACT_DECODE, 8'd0,   7'd0,   64'd0, 1'b0, 1'b0, 0, 8'd0,   hbsd_pkg::ST_OK},
      '{hbsd_pkg::ACT_DECODE, 8'd0,   7'd0,   64'd0, 1'b1, 1'b1, 1, 8'd0,   hbsd_pkg::ST_END_MID},
      // over-long stored length, full-width code
      '{hbsd_pkg::ACT_LOAD,   8'd10,  7'd127, 64'd0, 1'b0, 1'b0, 0, 8'd0,   hbsd_pkg::ST_OK},
      '{hbsd_pkg::ACT_LOAD,   8'd11,  7'd64,  '1,    1'b1, 1'b1, 0, 8'd0,   hbsd_pkg::ST_OK},
      '{hbsd_pkg::ACT_DECODE, 8'hff,  7'h7f,  '1,    1'b1, 1'b0, 1, 8'd3,   hbsd_pkg::ST_OK},
      '{hbsd_pkg::ACT_LOAD,   8'd3,   7'd0,   64'd0, 1'b0, 1'b0, 0, 8'd0,   hbsd_pkg::ST_OK},
      '{hbsd_pkg::ACT_DECODE, 8'd0,   7'd0,   64'd0, 1'b1, 1'b1, 1, 8'd255, hbsd_pkg::ST_OK},
      '{hbsd_pkg::ACT_LOAD,   8'd255, 7'd64,  64'd0, 1'b0, 1'b0, 0, 8'd0,   hbsd_pkg::ST_OK},
      '{hbsd_pkg::ACT_DECODE, 8'd0,   7'd0,   64'd0, 1'b0, 1'b1, 1, 8'd0,   hbsd_pkg::ST_END_MID}
    };

    foreach (dict_len_m[i]) begin
      dict_len_m[i]  = '0;
      dict_code_m[i] = '0;
    end
    acc_code_m = '0;
    acc_len_m  = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (dir_tbl[r]) begin
      offer(dir_tbl[r].act, dir_tbl[r].idx, dir_tbl[r].len, dir_tbl[r].code,
            dir_tbl[r].b, dir_tbl[r].e, has, res);
      if (dir_tbl[r].chk && (!has || res.sym != dir_tbl[r].sym || res.st != dir_tbl[r].st))
        report($sformatf("table row %0d", r), 64'({res.sym, res.st}),
               64'({dir_tbl[r].sym, dir_tbl[r].st}));
    end

    // Clear the dictionary, then a full 64-bit code and an over-long code
    for (int i = 0; i < hbsd_pkg::SYMBOLS; i++) load_entry(i[7:0], 7'd0, rnd64());
    c64 = rnd64();
    load_entry(8'd200, 7'd64, c64);
    for (int p = 63; p >= 0; p--) decode_bit(c64[p], 1'b0);
    load_entry(8'd200, 7'd0, 64'd0);
    for (int p = 0; p < 64; p++) decode_bit(1'($urandom_range(1)), 1'b0);
    decode_bit(1'($urandom_range(1)), 1'b1);  // too long wins over stream end

    // Random codebooks and streams
    for (int seg = 0; n_sent < ITEMS_TARGET; seg++) begin
      if (seg == 2) hold_req = 1'b1;
      quiet = (seg >= 5 && seg < 8);
      if (seg == 9) begin
        in_valid <= 1'b0;
        wait (pending_q.size() == 0);
        @(posedge clk);
      end
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(12, 4)) begin
          if ($urandom_range(1))
            load_entry(8'($urandom_range(255)), 7'($urandom_range(127)), rnd64());
          else
            decode_bit(1'($urandom_range(1)), $urandom_range(99) < 20);
        end
      end
      codebook_segment();
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    wait (pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
